@@ design/hpq_pkg.sv @@
package hpq_pkg;

	localparam int DEPTH  = 64;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CHILD_W = IDX_W + 1;

	typedef logic signed [31:0] val_t;
	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [CNT_W-1:0]   cnt_t;

	localparam val_t NEG_ONE = -32'sd1;

	localparam logic REQ_INSERT  = 1'b0;
	localparam logic REQ_EXTRACT = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_CHK,
		S_UP_CMP,
		S_EX_RD,
		S_EX_LAST,
		S_DN_L,
		S_DN_R,
		S_DN_CMP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic req_type;
		val_t value;
	} req_t;

	typedef struct packed {
		val_t        extracted;
		logic [1:0]  status;
		val_t        top_value;
		cnt_t        occupancy;
	} rsp_t;

	typedef struct packed {
		logic we;
		idx_t waddr;
		val_t wdata;
		idx_t raddr;
	} mem_req_t;

	function automatic logic val_gt(input val_t a, input val_t b);
		return a > b;
	endfunction

endpackage

@@ design/hpq_ram.sv @@
module hpq_ram
	import hpq_pkg::*;
(
	input  logic     clk,
	input  mem_req_t mem,
	output val_t     rdata
);

	val_t store_q [DEPTH];
	val_t rdata_q;

	always_ff @(posedge clk) begin
		if (mem.we) begin
			store_q[mem.waddr] <= mem.wdata;
		end
		rdata_q <= store_q[mem.raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/hpq_seq.sv @@
module hpq_seq
	import hpq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  req_t     req,
	input  val_t     rdata,
	output mem_req_t mem,
	output logic     busy,
	output logic     done,
	output rsp_t     result
);

	state_t  state_q, state_d;
	cnt_t    count_q, count_d;
	idx_t    idx_q, idx_d;
	val_t    val_q, val_d;
	val_t    best_q, best_d;
	logic    bleft_q, bleft_d;
	val_t    ext_q, ext_d;
	status_t status_q, status_d;
	val_t    root_q;

	idx_t                 parent;
	logic [CHILD_W-1:0]   left, right, n_ext;
	val_t                 cmp_a, cmp_b;
	logic                 gt;

	always_comb begin
		parent = idx_t'((idx_q - idx_t'(1)) >> 1);
		left   = {idx_q, 1'b1};
		right  = {idx_q, 1'b0} + CHILD_W'(2);
		n_ext  = CHILD_W'(count_q);
	end

	// single shared signed compare
	always_comb begin
		if (state_q == S_UP_CMP) begin
			cmp_a = val_q;
			cmp_b = rdata;
		end else if (state_q == S_DN_CMP) begin
			cmp_a = rdata;
			cmp_b = best_q;
		end else begin
			cmp_a = rdata;
			cmp_b = val_q;
		end
		gt = val_gt(cmp_a, cmp_b);
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		val_d     = val_q;
		best_d    = best_q;
		bleft_d   = bleft_q;
		ext_d     = ext_q;
		status_d  = status_q;
		mem.we    = 1'b0;
		mem.waddr = idx_q;
		mem.wdata = val_q;
		mem.raddr = idx_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ext_d    = NEG_ONE;
					status_d = ST_OK;
					if (req.req_type == REQ_INSERT) begin
						if (count_q == cnt_t'(DEPTH)) begin
							status_d = ST_FULL;
							state_d  = S_DONE;
						end else begin
							idx_d   = count_q[IDX_W-1:0];
							val_d   = req.value;
							count_d = count_q + cnt_t'(1);
							state_d = S_UP_CHK;
						end
					end else begin
						if (count_q == '0) begin
							status_d = ST_EMPTY;
							state_d  = S_DONE;
						end else begin
							ext_d   = root_q;
							count_d = count_q - cnt_t'(1);
							state_d = (count_q == cnt_t'(1)) ? S_DONE : S_EX_RD;
						end
					end
				end
			end
			S_UP_CHK: begin
				if (idx_q == '0) begin
					mem.we  = 1'b1;
					state_d = S_DONE;
				end else begin
					mem.raddr = parent;
					state_d   = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				mem.we = 1'b1;
				if (gt) begin
					// parent moves down into the hole
					mem.wdata = rdata;
					idx_d     = parent;
					state_d   = S_UP_CHK;
				end else begin
					state_d = S_DONE;
				end
			end
			S_EX_RD: begin
				mem.raddr = count_q[IDX_W-1:0];
				state_d   = S_EX_LAST;
			end
			S_EX_LAST: begin
				val_d   = rdata;
				idx_d   = '0;
				state_d = S_DN_L;
			end
			S_DN_L: begin
				if (left < n_ext) begin
					mem.raddr = left[IDX_W-1:0];
					state_d   = S_DN_R;
				end else begin
					mem.we  = 1'b1;
					state_d = S_DONE;
				end
			end
			S_DN_R: begin
				best_d  = gt ? rdata : val_q;
				bleft_d = gt;
				if (right < n_ext) begin
					mem.raddr = right[IDX_W-1:0];
					state_d   = S_DN_CMP;
				end else if (gt) begin
					mem.we    = 1'b1;
					mem.wdata = rdata;
					idx_d     = left[IDX_W-1:0];
					state_d   = S_DN_L;
				end else begin
					mem.we  = 1'b1;
					state_d = S_DONE;
				end
			end
			S_DN_CMP: begin
				mem.we = 1'b1;
				if (gt) begin
					mem.wdata = rdata;
					idx_d     = right[IDX_W-1:0];
					state_d   = S_DN_L;
				end else if (bleft_q) begin
					mem.wdata = best_q;
					idx_d     = left[IDX_W-1:0];
					state_d   = S_DN_L;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		val_q    <= val_d;
		best_q   <= best_d;
		bleft_q  <= bleft_d;
		ext_q    <= ext_d;
		status_q <= status_d;
		// shadow of slot 0 for the top_value report
		if (mem.we && mem.waddr == '0) begin
			root_q <= mem.wdata;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	always_comb begin
		result.extracted = ext_q;
		result.status    = status_q;
		result.top_value = (count_q == '0) ? NEG_ONE : root_q;
		result.occupancy = count_q;
	end

endmodule

@@ design/max_heap_priority_queue_core.sv @@
// Binary max-heap priority queue of signed 32-bit values, DEPTH entries.
//
// Request: drive req (req_type, value) with start high; the word is taken
// at a rising edge where start is high and busy is low. busy stays high
// until the result has been shown.
// Result: result (extracted, status, top_value, occupancy) is valid for
// exactly one cycle while done is high; the receiver cannot stall it.
// Exactly one result per request.
//
// The work per request, from the accept cycle through the done cycle, is set by the
// one-read-port heap memory and the single shared compare, one level per pass:
//   insert : the new value climbs a level per pass until it stops below a parent or at the root
//   extract: the last element moves to the root and sinks a level per pass
//   empty extract, full insert, extract of the only element: straight to done
// One request is worked at a time; the next is taken the cycle after done.
//
// Reset (arst_n low) empties the queue at once; the store is not cleared,
// only slots below the count are ever read.
module max_heap_priority_queue_core
	import hpq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t result
);

	mem_req_t mem;
	val_t     rdata;

	hpq_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.rdata  (rdata),
		.mem    (mem),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	hpq_ram u_ram (
		.clk   (clk),
		.mem   (mem),
		.rdata (rdata)
	);

endmodule

@@ design/hpq_chk.sv @@
module hpq_chk
	import hpq_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t result
);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done without busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done longer than one cycle");

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.occupancy <= cnt_t'(DEPTH)))
		else $error("occupancy above depth");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.occupancy == '0) |-> (result.top_value == NEG_ONE))
		else $error("empty queue reports a top value");

endmodule

bind max_heap_priority_queue_core hpq_chk u_hpq_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
